[hdl/vctp_pkg.sv]
// Package for the vertex camera transform and projection unit.
// Holds the payload structs, register indexes, the sine table and small arithmetic helpers.
// It depends on no other file.
package vctp_pkg;

  localparam int AngleSteps = 256;
  localparam int AngleBits  = $clog2(AngleSteps);
  localparam int CenterX    = 160;
  localparam int CenterY    = 100;

  // Quotient magnitude bits and divider stages (two bits per stage).
  localparam int DivBits   = 30;
  localparam int DivStages = DivBits / 2;

  localparam logic [2:0] CfgCamPosX   = 3'd0;
  localparam logic [2:0] CfgCamPosY   = 3'd1;
  localparam logic [2:0] CfgCamPosZ   = 3'd2;
  localparam logic [2:0] CfgPitch     = 3'd3;
  localparam logic [2:0] CfgYaw       = 3'd4;
  localparam logic [2:0] CfgRoll      = 3'd5;
  localparam logic [2:0] CfgFocal     = 3'd6;

  typedef struct packed {
    logic signed [15:0] world_x;
    logic signed [15:0] world_y;
    logic signed [15:0] world_z;
  } vtx_in_t;

  typedef struct packed {
    logic signed [15:0] view_x;
    logic signed [15:0] view_y;
    logic signed [15:0] view_z;
    logic signed [15:0] proj_x;
    logic signed [15:0] proj_y;
    logic               visible;
  } vtx_out_t;

  typedef struct packed {
    logic signed [9:0] s;
    logic signed [9:0] c;
  } trig_t;

  typedef struct packed {
    logic [14:0]        rem;
    logic [DivBits-1:0] quo;
  } div_st_t;

  // Rounded unsigned 1.8 sine over the first quarter turn, index 0 to 64.
  function automatic logic [8:0] quarter_sine(input logic [6:0] k);
    logic [8:0] v;
    case (k)
      7'd0: v = 9'd0;     7'd1: v = 9'd6;     7'd2: v = 9'd13;    7'd3: v = 9'd19;
      7'd4: v = 9'd25;    7'd5: v = 9'd31;    7'd6: v = 9'd38;    7'd7: v = 9'd44;
      7'd8: v = 9'd50;    7'd9: v = 9'd56;    7'd10: v = 9'd62;   7'd11: v = 9'd68;
      7'd12: v = 9'd74;   7'd13: v = 9'd80;   7'd14: v = 9'd86;   7'd15: v = 9'd92;
      7'd16: v = 9'd98;   7'd17: v = 9'd104;  7'd18: v = 9'd109;  7'd19: v = 9'd115;
      7'd20: v = 9'd121;  7'd21: v = 9'd126;  7'd22: v = 9'd132;  7'd23: v = 9'd137;
      7'd24: v = 9'd142;  7'd25: v = 9'd147;  7'd26: v = 9'd152;  7'd27: v = 9'd157;
      7'd28: v = 9'd162;  7'd29: v = 9'd167;  7'd30: v = 9'd172;  7'd31: v = 9'd177;
      7'd32: v = 9'd181;  7'd33: v = 9'd185;  7'd34: v = 9'd190;  7'd35: v = 9'd194;
      7'd36: v = 9'd198;  7'd37: v = 9'd202;  7'd38: v = 9'd206;  7'd39: v = 9'd209;
      7'd40: v = 9'd213;  7'd41: v = 9'd216;  7'd42: v = 9'd220;  7'd43: v = 9'd223;
      7'd44: v = 9'd226;  7'd45: v = 9'd229;  7'd46: v = 9'd231;  7'd47: v = 9'd234;
      7'd48: v = 9'd237;  7'd49: v = 9'd239;  7'd50: v = 9'd241;  7'd51: v = 9'd243;
      7'd52: v = 9'd245;  7'd53: v = 9'd247;  7'd54: v = 9'd248;  7'd55: v = 9'd250;
      7'd56: v = 9'd251;  7'd57: v = 9'd252;  7'd58: v = 9'd253;  7'd59: v = 9'd254;
      7'd60: v = 9'd255;  7'd61: v = 9'd255;  7'd62: v = 9'd256;  7'd63: v = 9'd256;
      7'd64: v = 9'd256;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Full-turn signed sine built from the quarter table by symmetry.
  function automatic logic signed [9:0] sine8(input logic [AngleBits-1:0] a);
    logic [6:0] idx;
    logic [9:0] mag;
    idx = a[AngleBits-2] ? 7'(7'd64 - {1'b0, a[AngleBits-3:0]}) : {1'b0, a[AngleBits-3:0]};
    mag = {1'b0, quarter_sine(idx)};
    return a[AngleBits-1] ? $signed(-mag) : $signed(mag);
  endfunction

  // Rotation by the negated angle: sine flips sign, cosine stays.
  function automatic trig_t trig_neg(input logic [AngleBits-1:0] r);
    trig_t t;
    t.s = -sine8(r);
    t.c = sine8(AngleBits'(r + AngleBits'(AngleSteps / 4)));
    return t;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7FFF;
    if (v < -32'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Divide a rotation sum by 256 with truncation toward zero, then saturate.
  function automatic logic signed [15:0] shrink(input logic signed [27:0] v);
    logic signed [27:0] b;
    logic signed [19:0] t;
    b = v + $signed({20'd0, {8{v[27]}}});
    t = 20'(b >>> 8);
    return sat16(32'(t));
  endfunction

  // One restoring division step.
  function automatic div_st_t div_step(input div_st_t st, input logic [14:0] d);
    div_st_t    n;
    logic [15:0] r2;
    logic        ge;
    r2    = {st.rem, st.quo[DivBits-1]};
    ge    = r2 >= {1'b0, d};
    n.rem = ge ? 15'(r2 - {1'b0, d}) : r2[14:0];
    n.quo = {st.quo[DivBits-2:0], ge};
    return n;
  endfunction

endpackage

[hdl/vertex_camera_transform_project_unit.sv]
// Vertex camera transform and perspective projection unit, top level.
// An accepted start leads to one done_o strobe with its result; one vertex per cycle.
// Throughput is set by the fully pipelined design: seven rotation and scaling stages and a
// fifteen-stage restoring divider that resolves two quotient bits per stage.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the register defaults.
// The receiver cannot stall, so busy stays low.
module vertex_camera_transform_project_unit
  import vctp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  vtx_in_t         vertex_i,
  output logic            done_o,
  output vtx_out_t        result_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i
);

  // The pipeline never stalls, so both sides are always ready.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes to an index beyond the list are dropped.
  // ---------------------------------------------------------------------------
  logic signed [15:0]    cam_x_q, cam_y_q, cam_z_q;
  logic [AngleBits-1:0]  pitch_q, yaw_q, roll_q;
  logic [14:0]           focal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= 16'sd0;
      cam_y_q <= 16'sd0;
      cam_z_q <= -16'sd100;
      pitch_q <= '0;
      yaw_q   <= '0;
      roll_q  <= '0;
      focal_q <= 15'd100;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgCamPosX: cam_x_q <= cfg_data_i;
        CfgCamPosY: cam_y_q <= cfg_data_i;
        CfgCamPosZ: cam_z_q <= cfg_data_i;
        CfgPitch:   pitch_q <= cfg_data_i[AngleBits-1:0];
        CfgYaw:     yaw_q   <= cfg_data_i[AngleBits-1:0];
        CfgRoll:    roll_q  <= cfg_data_i[AngleBits-1:0];
        CfgFocal:   focal_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // The user must change the configuration only while idle; the block does not enforce this.
  // This lets the sine and cosine be looked up in the stage that uses them.
  trig_t yaw_t, pitch_t, roll_t;
  assign yaw_t   = trig_neg(yaw_q);
  assign pitch_t = trig_neg(pitch_q);
  assign roll_t  = trig_neg(roll_q);

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Stage 1: translate and form the yaw products. The differences are exact 17-bit values.
  // ---------------------------------------------------------------------------
  logic signed [16:0] dx, dy, dz;
  assign dx = 17'(vertex_i.world_x) - 17'(cam_x_q);
  assign dy = 17'(vertex_i.world_y) - 17'(cam_y_q);
  assign dz = 17'(vertex_i.world_z) - 17'(cam_z_q);

  logic               v1_q;
  logic signed [26:0] p1_xc_q, p1_zs_q, p1_zc_q, p1_xs_q;
  logic signed [16:0] y1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    p1_xc_q <= 27'(dx) * 27'(yaw_t.c);
    p1_zs_q <= 27'(dz) * 27'(yaw_t.s);
    p1_zc_q <= 27'(dz) * 27'(yaw_t.c);
    p1_xs_q <= 27'(dx) * 27'(yaw_t.s);
    y1_q    <= dy;
  end

  // Stage 2: finish the yaw rotation.
  logic               v2_q;
  logic signed [15:0] x2_q, z2_q;
  logic signed [16:0] y2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    x2_q <= shrink(28'(p1_xc_q) + 28'(p1_zs_q));
    z2_q <= shrink(28'(p1_zc_q) - 28'(p1_xs_q));
    y2_q <= y1_q;
  end

  // Stage 3: pitch products.
  logic               v3_q;
  logic signed [26:0] p3_yc_q, p3_zs_q, p3_ys_q, p3_zc_q;
  logic signed [15:0] x3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    p3_yc_q <= 27'(y2_q) * 27'(pitch_t.c);
    p3_zs_q <= 27'(z2_q) * 27'(pitch_t.s);
    p3_ys_q <= 27'(y2_q) * 27'(pitch_t.s);
    p3_zc_q <= 27'(z2_q) * 27'(pitch_t.c);
    x3_q    <= x2_q;
  end

  // Stage 4: finish the pitch rotation.
  logic               v4_q;
  logic signed [15:0] x4_q, y4_q, z4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    y4_q <= shrink(28'(p3_yc_q) - 28'(p3_zs_q));
    z4_q <= shrink(28'(p3_ys_q) + 28'(p3_zc_q));
    x4_q <= x3_q;
  end

  // Stage 5: roll products.
  logic               v5_q;
  logic signed [26:0] p5_xc_q, p5_ys_q, p5_xs_q, p5_yc_q;
  logic signed [15:0] z5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    p5_xc_q <= 27'(x4_q) * 27'(roll_t.c);
    p5_ys_q <= 27'(y4_q) * 27'(roll_t.s);
    p5_xs_q <= 27'(x4_q) * 27'(roll_t.s);
    p5_yc_q <= 27'(y4_q) * 27'(roll_t.c);
    z5_q    <= z4_q;
  end

  // Stage 6: finish the roll rotation; the view coordinates are final here.
  logic               v6_q;
  logic signed [15:0] x6_q, y6_q, z6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else         v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    x6_q <= shrink(28'(p5_xc_q) - 28'(p5_ys_q));
    y6_q <= shrink(28'(p5_xs_q) + 28'(p5_yc_q));
    z6_q <= z5_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 7: scale by the focal length and split into sign and magnitude for the
  // divider. The magnitude of a 16 by 15 bit product always fits in 30 bits.
  // ---------------------------------------------------------------------------
  logic signed [31:0] fx, fy;
  assign fx = 32'(x6_q) * $signed({17'd0, focal_q});
  assign fy = 32'(y6_q) * $signed({17'd0, focal_q});

  logic               dv_valid_q [DivStages+1];
  div_st_t            dv_a_q     [DivStages+1];
  div_st_t            dv_b_q     [DivStages+1];
  logic               dv_nega_q  [DivStages+1];
  logic               dv_negb_q  [DivStages+1];
  logic [14:0]        dv_den_q   [DivStages+1];
  logic               dv_vis_q   [DivStages+1];
  logic signed [15:0] dv_vx_q    [DivStages+1];
  logic signed [15:0] dv_vy_q    [DivStages+1];
  logic signed [15:0] dv_vz_q    [DivStages+1];

  logic signed [31:0] fx_abs, fy_abs;
  assign fx_abs = fx[31] ? -fx : fx;
  assign fy_abs = fy[31] ? -fy : fy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_valid_q[0] <= 1'b0;
    else         dv_valid_q[0] <= v6_q;
  end

  always_ff @(posedge clk_i) begin
    dv_a_q[0].rem <= '0;
    dv_a_q[0].quo <= fx_abs[DivBits-1:0];
    dv_b_q[0].rem <= '0;
    dv_b_q[0].quo <= fy_abs[DivBits-1:0];
    dv_nega_q[0]  <= fx[31];
    dv_negb_q[0]  <= fy[31];
    // A positive depth is below 2^15; other depths are masked at the output.
    dv_den_q[0]   <= z6_q[14:0];
    dv_vis_q[0]   <= z6_q > 16'sd0;
    dv_vx_q[0]    <= x6_q;
    dv_vy_q[0]    <= y6_q;
    dv_vz_q[0]    <= z6_q;
  end

  // Divider stages: each resolves two quotient bits for both screen axes.
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_valid_q[g+1] <= 1'b0;
      else         dv_valid_q[g+1] <= dv_valid_q[g];
    end

    always_ff @(posedge clk_i) begin
      dv_a_q[g+1]    <= div_step(div_step(dv_a_q[g], dv_den_q[g]), dv_den_q[g]);
      dv_b_q[g+1]    <= div_step(div_step(dv_b_q[g], dv_den_q[g]), dv_den_q[g]);
      dv_nega_q[g+1] <= dv_nega_q[g];
      dv_negb_q[g+1] <= dv_negb_q[g];
      dv_den_q[g+1]  <= dv_den_q[g];
      dv_vis_q[g+1]  <= dv_vis_q[g];
      dv_vx_q[g+1]   <= dv_vx_q[g];
      dv_vy_q[g+1]   <= dv_vy_q[g];
      dv_vz_q[g+1]   <= dv_vz_q[g];
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: restore the sign, add the screen center and saturate. Points at or
  // behind the camera report zero screen coordinates.
  // ---------------------------------------------------------------------------
  logic signed [31:0] qx, qy, sx, sy;
  assign qx = dv_nega_q[DivStages] ? -$signed({2'b00, dv_a_q[DivStages].quo})
                                   :  $signed({2'b00, dv_a_q[DivStages].quo});
  assign qy = dv_negb_q[DivStages] ? -$signed({2'b00, dv_b_q[DivStages].quo})
                                   :  $signed({2'b00, dv_b_q[DivStages].quo});
  assign sx = qx + 32'(CenterX);
  assign sy = qy + 32'(CenterY);

  logic     done_q;
  vtx_out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= dv_valid_q[DivStages];
  end

  always_ff @(posedge clk_i) begin
    res_q.view_x  <= dv_vx_q[DivStages];
    res_q.view_y  <= dv_vy_q[DivStages];
    res_q.view_z  <= dv_vz_q[DivStages];
    res_q.visible <= dv_vis_q[DivStages];
    res_q.proj_x  <= dv_vis_q[DivStages] ? sat16(sx) : 16'sd0;
    res_q.proj_y  <= dv_vis_q[DivStages] ? sat16(sy) : 16'sd0;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_visible_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.visible == (result_o.view_z > 16'sd0)))
    else $error("visible flag disagrees with depth");

  a_hidden_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.visible) |-> (result_o.proj_x == 16'sd0 &&
                                       result_o.proj_y == 16'sd0))
    else $error("hidden point has nonzero screen coordinates");

  a_div_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(dv_valid_q[0], DivStages + 1))
    else $error("result word without a matching divider entry");

endmodule

[test/vertex_camera_transform_project_unit_tb.sv]
// Self-checking testbench for the vertex camera transform and projection unit.
// Depends on vctp_pkg for the vertex payload structs and the register indexes.
module vertex_camera_transform_project_unit_tb
  import vctp_pkg::*;
;

  // Drain allowance: settling time after the last expected word is back, with margin.
  localparam int DrainCycles  = 40;
  localparam int IdleLimit    = 5000;
  localparam int RandomPhases = 12;
  localparam int PhaseItems   = 50;
  localparam logic [2:0] CfgUnused = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  vtx_in_t     vertex_i;
  logic        done_o;
  vtx_out_t    result_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  vertex_camera_transform_project_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .vertex_i    (vertex_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Our own copy of the camera registers, updated whenever a write is accepted.
  longint cam_x, cam_y, cam_z, focal;
  int     pitch, yaw, roll;
  // Signed 2.8 sine over a full turn of 256 steps.
  longint sine_lut [0:255];

  vtx_out_t projected_q[$];
  int       mismatches;
  int       words_sent;
  int       words_checked;
  int       idle_cycles;
  logic     activity;

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // The unit rotates by the negated angle, so the table index is the negated register.
  function automatic void angle_trig(int r, output longint s, output longint c);
    int i;
    i = (256 - r) % 256;
    s = sine_lut[i];
    c = sine_lut[(i + 64) % 256];
  endfunction

  // View transform (yaw, then pitch, then roll) followed by the perspective divide.
  // SystemVerilog integer division truncates toward zero, matching the hardware.
  function automatic vtx_out_t project_vertex(vtx_in_t v);
    longint x, y, z, s, c, nx, ny, nz;
    vtx_out_t r;
    x = longint'(v.world_x) - cam_x;
    y = longint'(v.world_y) - cam_y;
    z = longint'(v.world_z) - cam_z;
    angle_trig(yaw, s, c);
    nx = clamp16((x * c + z * s) / 256);
    nz = clamp16((z * c - x * s) / 256);
    x = nx; z = nz;
    angle_trig(pitch, s, c);
    ny = clamp16((y * c - z * s) / 256);
    nz = clamp16((y * s + z * c) / 256);
    y = ny; z = nz;
    angle_trig(roll, s, c);
    nx = clamp16((x * c - y * s) / 256);
    ny = clamp16((x * s + y * c) / 256);
    x = nx; y = ny;
    r.view_x = 16'(x);
    r.view_y = 16'(y);
    r.view_z = 16'(z);
    if (z > 0) begin
      r.visible = 1'b1;
      r.proj_x  = 16'(clamp16((x * focal) / z + 160));
      r.proj_y  = 16'(clamp16((y * focal) / z + 100));
    end else begin
      r.visible = 1'b0;
      r.proj_x  = '0;
      r.proj_y  = '0;
    end
    return r;
  endfunction

  // Build the table from one rounded quarter turn so the symmetry is exact.
  initial begin
    longint quarter [0:64];
    for (int k = 0; k <= 64; k++) begin
      quarter[k] = longint'($rtoi(256.0 * $sin(2.0 * 3.14159265358979 * k / 256.0) + 0.5));
    end
    for (int i = 0; i < 256; i++) begin
      if (i <= 64) sine_lut[i] = quarter[i];
      else if (i <= 128) sine_lut[i] = quarter[128 - i];
      else if (i <= 192) sine_lut[i] = -quarter[i - 128];
      else sine_lut[i] = -quarter[256 - i];
    end
  end

  // Result monitor. Every done_o word is compared with the oldest projection waiting.
  always @(posedge clk_i) begin
    vtx_out_t want;
    if (rst_ni && done_o) begin
      if (projected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", result_o);
      end else begin
        want = projected_q.pop_front();
        words_checked++;
        if (result_o !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: want %p got %p", want, result_o);
        end
      end
    end
  end

  // Watchdog: any accepted word on any channel resets the idle count.
  always @(posedge clk_i) begin
    activity = (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o);
    if (!rst_ni || activity) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // A register write; it is only ever issued while the pipeline is empty.
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgCamPosX: cam_x = longint'($signed(data));
      CfgCamPosY: cam_y = longint'($signed(data));
      CfgCamPosZ: cam_z = longint'($signed(data));
      CfgPitch:   pitch = int'(data[7:0]);
      CfgYaw:     yaw   = int'(data[7:0]);
      CfgRoll:    roll  = int'(data[7:0]);
      CfgFocal:   focal = longint'(data[14:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Send one vertex word. start is left high so back-to-back words form a burst.
  // A typed expectation replaces the prediction for rows whose answer is plain.
  task automatic send_vertex(vtx_in_t v, bit typed, vtx_out_t typed_res);
    @(negedge clk_i);
    start    <= 1'b1;
    vertex_i <= v;
    do @(posedge clk_i); while (busy);
    projected_q.push_back(typed ? typed_res : project_vertex(v));
    words_sent++;
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Hold off until every projection is back, then let the pipeline settle.
  task automatic drain();
    pause_sender(0);
    while (projected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed($urandom_range(0, 400)) - 200);
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  typedef struct {
    vtx_in_t  v;
    bit       typed;
    vtx_out_t res;
  } vertex_row_t;

  vertex_row_t directed [] = '{
    // Origin seen from the reset camera at z = -100 lands on the screen center.
    '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd100, 16'sd160, 16'sd100, 1'b1}},
    // Zero depth: not visible, screen cleared.
    '{'{16'sd0, 16'sd0, -16'sd100}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
    // Largest corner: depth saturates to 32767.
    '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b1,
      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd260, 16'sd200, 1'b1}},
    '{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
    '{'{16'sh8000, 16'sh7FFF, 16'sd1}, 1'b0, '0},
    '{'{16'sh7FFF, 16'sh8000, -16'sd99}, 1'b0, '0},
    '{'{16'sd5, -16'sd7, -16'sd200}, 1'b0, '0},
    '{'{16'sd1000, -16'sd1000, 16'sd50}, 1'b0, '0}
  };

  initial begin
    int n_items;
    int burst;
    vtx_in_t v;
    rst_ni      = 1'b0;
    start       = 1'b0;
    vertex_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgCamPosX;
    cfg_data_i  = '0;
    mismatches  = 0;
    words_sent  = 0;
    words_checked = 0;
    idle_cycles = 0;
    cam_x = 0; cam_y = 0; cam_z = -100; focal = 100;
    pitch = 0; yaw = 0; roll = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows under the reset registers.
    foreach (directed[i]) send_vertex(directed[i].v, directed[i].typed, directed[i].res);
    drain();

    // Extreme settings: far camera, quarter and half turns, largest focal length.
    write_reg(CfgCamPosX, 16'h8000);
    write_reg(CfgCamPosY, 16'h7FFF);
    write_reg(CfgCamPosZ, 16'h8000);
    write_reg(CfgPitch, 16'd64);
    write_reg(CfgYaw, 16'd128);
    write_reg(CfgRoll, 16'd255);
    write_reg(CfgFocal, 16'h7FFF);
    for (int i = 3; i < directed.size(); i++) send_vertex(directed[i].v, 1'b0, '0);
    drain();

    // Zero focal length and a write to an unused index.
    write_reg(CfgCamPosX, 16'd0);
    write_reg(CfgCamPosY, 16'd0);
    write_reg(CfgCamPosZ, 16'hFF9C);
    write_reg(CfgPitch, 16'd0);
    write_reg(CfgYaw, 16'd0);
    write_reg(CfgRoll, 16'd0);
    write_reg(CfgFocal, 16'h8000);
    write_reg(CfgUnused, 16'hFFFF);
    send_vertex('{16'sd40, -16'sd30, 16'sd0}, 1'b0, '0);
    send_vertex('{16'sh7FFF, 16'sh8000, 16'sh7FFF}, 1'b0, '0);
    drain();

    // Random phases: new registers each phase, bursty vertex traffic in between.
    for (int p = 0; p < RandomPhases; p++) begin
      write_reg(CfgCamPosX, $urandom_range(0, 1) ? 16'($urandom) : rand_coord());
      write_reg(CfgCamPosY, rand_coord());
      write_reg(CfgCamPosZ, rand_coord());
      write_reg(CfgPitch, 16'($urandom));
      write_reg(CfgYaw, 16'($urandom));
      write_reg(CfgRoll, 16'($urandom));
      write_reg(CfgFocal, $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                   : 16'($urandom_range(1, 400)));
      if ($urandom_range(0, 3) == 0) write_reg(CfgUnused, 16'($urandom));
      n_items = 0;
      while (n_items < PhaseItems) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst; b++) begin
          v.world_x = rand_coord();
          v.world_y = rand_coord();
          v.world_z = rand_coord();
          send_vertex(v, 1'b0, '0);
          n_items++;
        end
        // Some bursts run straight into the next one with no gap.
        if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 20));
      end
      drain();
    end

    $display("sent %0d vertex words over %0d register settings, checked %0d results",
             words_sent, RandomPhases + 3, words_checked);
    if (mismatches == 0 && projected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, projected_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
